### src/wheel_sensor_debounce_tachometer_macros.svh
// Assertion macros of the wheel sensor debounce and tachometer RTL.
`ifndef WHEEL_SENSOR_DEBOUNCE_TACHOMETER_MACROS_SVH
`define WHEEL_SENSOR_DEBOUNCE_TACHOMETER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsdt assertion failed");

// Next-cycle implication, disabled during reset.
`define WSDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsdt assertion failed");

`endif

### src/wsdt_pkg.sv
// Types and constants of the wheel sensor debounce and tachometer.
package wsdt_pkg;

	localparam int unsigned PADDR_W = 4;

	localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd3;
	localparam logic [7:0]  RUN_LENGTH_CAP_RST = 8'd99;
	localparam logic [15:0] WINDOW_TICKS_RST   = 16'd2000;

	typedef enum logic [1:0] {
		REG_DEBOUNCE_LIMIT = 2'd0,
		REG_RUN_LENGTH_CAP = 2'd1,
		REG_WINDOW_TICKS   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  debounce_limit;
		logic [7:0]  run_length_cap;
		logic [15:0] window_ticks;
	} cfg_t;

	typedef struct packed {
		logic        debounced_active;
		logic        wheel_pulse;
		logic [7:0]  inactive_run_length;
		logic [7:0]  active_run_length;
		logic [15:0] speed_count;
		logic        window_done;
	} res_t;

endpackage

### src/wsdt_regs.sv
// APB configuration registers of the wheel sensor debounce and tachometer.
module wsdt_regs
	import wsdt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_limit <= DEBOUNCE_LIMIT_RST;
			cfg_q.run_length_cap <= RUN_LENGTH_CAP_RST;
			cfg_q.window_ticks   <= WINDOW_TICKS_RST;
		end else if (wr) begin
			unique case (idx)
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= pwdata[7:0];
				REG_RUN_LENGTH_CAP: cfg_q.run_length_cap <= pwdata[7:0];
				REG_WINDOW_TICKS:   cfg_q.window_ticks   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEBOUNCE_LIMIT: prdata = {24'd0, cfg_q.debounce_limit};
			REG_RUN_LENGTH_CAP: prdata = {24'd0, cfg_q.run_length_cap};
			REG_WINDOW_TICKS:   prdata = {16'd0, cfg_q.window_ticks};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

### src/wsdt_core.sv
// Debounce integrator, run-length meter and speed window state with next-word logic.
`include "wheel_sensor_debounce_tachometer_macros.svh"

module wsdt_core
	import wsdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic pin_level,
	input  cfg_t cfg,
	output res_t res
);

	logic [7:0]  integrator_q, integrator_d;
	logic        debounced_q, debounced_d;
	logic        last_active_q, last_active_d;
	logic [7:0]  run_q, run_d;
	logic [7:0]  inactive_run_q, inactive_run_d;
	logic [7:0]  active_run_q, active_run_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] pulse_cnt_q, pulse_cnt_d;
	logic [15:0] speed_q, speed_d;

	logic        active;
	logic        pulse;
	logic        done;
	logic [7:0]  run_inc;
	logic [15:0] pulse_inc;
	logic [16:0] tick_inc;

	assign active = !pin_level;

	always_comb begin
		integrator_d = integrator_q;
		debounced_d  = debounced_q;
		pulse        = 1'b0;
		if (active) begin
			if (integrator_q < cfg.debounce_limit) begin
				integrator_d = integrator_q + 8'd1;
				if (integrator_d == cfg.debounce_limit && !debounced_q) begin
					debounced_d = 1'b1;
					pulse       = 1'b1;
				end
			end
		end else if (integrator_q != 8'd0) begin
			integrator_d = integrator_q - 8'd1;
			if (integrator_d == 8'd0) begin
				debounced_d = 1'b0;
			end
		end
	end

	// Latch into the output of the level that is running (or just ended).
	always_comb begin
		run_inc        = (run_q < cfg.run_length_cap) ? run_q + 8'd1 : run_q;
		run_d          = run_inc;
		last_active_d  = last_active_q;
		inactive_run_d = inactive_run_q;
		active_run_d   = active_run_q;
		if (active == last_active_q) begin
			if (run_inc == cfg.run_length_cap) begin
				if (last_active_q) begin
					active_run_d = run_inc;
				end else begin
					inactive_run_d = run_inc;
				end
			end
		end else begin
			if (last_active_q) begin
				active_run_d = run_q;
			end else begin
				inactive_run_d = run_q;
			end
			last_active_d = active;
			run_d         = 8'd1;
		end
	end

	always_comb begin
		pulse_inc = pulse ? pulse_cnt_q + 16'd1 : pulse_cnt_q;
		tick_inc  = {1'b0, tick_q} + 17'd1;
		done      = tick_inc >= {1'b0, cfg.window_ticks};
		if (done) begin
			speed_d     = pulse_inc;
			pulse_cnt_d = 16'd0;
			tick_d      = 16'd0;
		end else begin
			speed_d     = speed_q;
			pulse_cnt_d = pulse_inc;
			tick_d      = tick_inc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integrator_q   <= '0;
			debounced_q    <= 1'b0;
			last_active_q  <= 1'b0;
			run_q          <= '0;
			inactive_run_q <= '0;
			active_run_q   <= '0;
			tick_q         <= '0;
			pulse_cnt_q    <= '0;
			speed_q        <= '0;
		end else if (advance) begin
			integrator_q   <= integrator_d;
			debounced_q    <= debounced_d;
			last_active_q  <= last_active_d;
			run_q          <= run_d;
			inactive_run_q <= inactive_run_d;
			active_run_q   <= active_run_d;
			tick_q         <= tick_d;
			pulse_cnt_q    <= pulse_cnt_d;
			speed_q        <= speed_d;
		end
	end

	always_comb begin
		res.debounced_active    = debounced_d;
		res.wheel_pulse         = pulse;
		res.inactive_run_length = inactive_run_d;
		res.active_run_length   = active_run_d;
		res.speed_count         = speed_d;
		res.window_done         = done;
	end

	`WSDT_ASSERT_SAME(a_deb_needs_integ, clk, arst_n, debounced_q, integrator_q != 8'd0)
	`WSDT_ASSERT_NEXT(a_pulse_sets_deb, clk, arst_n, advance && pulse, debounced_q)
	`WSDT_ASSERT_NEXT(a_done_clears, clk, arst_n, advance && done,
		tick_q == 16'd0 && pulse_cnt_q == 16'd0)
	`WSDT_ASSERT_NEXT(a_hold_idle, clk, arst_n, !advance,
		$stable(integrator_q) && $stable(tick_q) && $stable(run_q))

endmodule

### src/wheel_sensor_debounce_tachometer.sv
// Top level of the wheel sensor debounce and tachometer.
//
// Takes one sampled pin level per word and returns one result word per input word. A new
// word is accepted on every clock while the output side keeps up. An accepted word waits in
// the input register; the next free edge loads the result register through the combinational
// debounce, run-length and speed-window update, so a word passes the input register and then
// the result register before its result is offered. With both registers full,
// in_ready follows out_ready, so the next word is taken in the same cycle a waiting result
// is taken.
// Registers: debounce_limit at 0x0, run_length_cap at 0x4, window_ticks at 0x8; write
// them only while no word is in flight.
module wheel_sensor_debounce_tachometer
	import wsdt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               pin_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               debounced_active,
	output logic               wheel_pulse,
	output logic [7:0]         inactive_run_length,
	output logic [7:0]         active_run_length,
	output logic [15:0]        speed_count,
	output logic               window_done
);

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1_q;
	logic pin_s1;
	logic valid_s2_q;
	logic advance;

	wsdt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wsdt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// Move the input word into the result register when that slot is free or draining.
	assign advance  = valid_s1_q && (!valid_s2_q || out_ready);
	assign in_ready = !valid_s1_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1_q <= 1'b1;
			end else if (advance) begin
				valid_s1_q <= 1'b0;
			end
			if (advance) begin
				valid_s2_q <= 1'b1;
			end else if (out_ready) begin
				valid_s2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid           = valid_s2_q;
	assign debounced_active    = res_s2.debounced_active;
	assign wheel_pulse         = res_s2.wheel_pulse;
	assign inactive_run_length = res_s2.inactive_run_length;
	assign active_run_length   = res_s2.active_run_length;
	assign speed_count         = res_s2.speed_count;
	assign window_done         = res_s2.window_done;

endmodule

### test/tb_top.sv
// Self-checking testbench for the wheel sensor debounce and tachometer block.
`timescale 1ns / 1ps

module tb_top
	import wsdt_pkg::*;
();

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               pin_level;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               debounced_active;
	logic               wheel_pulse;
	logic [7:0]         inactive_run_length;
	logic [7:0]         active_run_length;
	logic [15:0]        speed_count;
	logic               window_done;

	wheel_sensor_debounce_tachometer uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.pin_level           (pin_level),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.debounced_active    (debounced_active),
		.wheel_pulse         (wheel_pulse),
		.inactive_run_length (inactive_run_length),
		.active_run_length   (active_run_length),
		.speed_count         (speed_count),
		.window_done         (window_done)
	);

	// Shadow copy of the block's registers and counters
	cfg_t        shadow_cfg = '{DEBOUNCE_LIMIT_RST, RUN_LENGTH_CAP_RST, WINDOW_TICKS_RST};
	logic [7:0]  integ_cnt    = '0;
	logic        deb_state    = 1'b0;
	logic        prev_active  = 1'b0;
	logic [7:0]  run_cnt      = '0;
	logic [7:0]  inactive_len = '0;
	logic [7:0]  active_len   = '0;
	logic [15:0] tick_cnt     = '0;
	logic [15:0] pulse_cnt    = '0;
	logic [15:0] speed_hold   = '0;

	res_t tick_results_due[$];
	int   mismatches    = 0;
	int   send_idle_pct = 14;
	int   recv_idle_pct = 46;
	bit   hold_output   = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#3_000_000;
		$display("** wheel_sensor_debounce_tachometer: FAILED **");
		$finish;
	end

	// Work out the result word that one pin sample produces.
	task automatic compute_tick_result(input logic lvl);
		logic        active;
		logic        pulse;
		logic        done;
		logic [16:0] next_tick;
		res_t        r;
		active = (lvl == 1'b0);
		pulse  = 1'b0;
		done   = 1'b0;
		if (active) begin
			if (integ_cnt < shadow_cfg.debounce_limit) begin
				integ_cnt = integ_cnt + 8'd1;
				if (integ_cnt == shadow_cfg.debounce_limit && !deb_state) begin
					deb_state = 1'b1;
					pulse     = 1'b1;
				end
			end
		end else if (integ_cnt > 8'd0) begin
			integ_cnt = integ_cnt - 8'd1;
			if (integ_cnt == 8'd0)
				deb_state = 1'b0;
		end
		// latch with the old run count on a level change, else while at the cap
		if (active == prev_active && run_cnt < shadow_cfg.run_length_cap)
			run_cnt = run_cnt + 8'd1;
		if (active != prev_active || run_cnt == shadow_cfg.run_length_cap) begin
			if (prev_active)
				active_len = run_cnt;
			else
				inactive_len = run_cnt;
		end
		if (active != prev_active) begin
			prev_active = active;
			run_cnt     = 8'd1;
		end
		if (pulse)
			pulse_cnt = pulse_cnt + 16'd1;
		next_tick = {1'b0, tick_cnt} + 17'd1;
		if (next_tick >= {1'b0, shadow_cfg.window_ticks}) begin
			speed_hold = pulse_cnt;
			pulse_cnt  = '0;
			tick_cnt   = '0;
			done       = 1'b1;
		end else begin
			tick_cnt = next_tick[15:0];
		end
		r.debounced_active    = deb_state;
		r.wheel_pulse         = pulse;
		r.inactive_run_length = inactive_len;
		r.active_run_length   = active_len;
		r.speed_count         = speed_hold;
		r.window_done         = done;
		tick_results_due.push_back(r);
	endtask

	// Enter and leave at a falling edge; valid stays high for a back-to-back word.
	task automatic send_tick(input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		pin_level <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		compute_tick_result(lvl);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tick_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_DEBOUNCE_LIMIT: shadow_cfg.debounce_limit = val[7:0];
			REG_RUN_LENGTH_CAP: shadow_cfg.run_length_cap = val[7:0];
			REG_WINDOW_TICKS:   shadow_cfg.window_ticks   = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(input int limit, input int cap, input int window);
		write_reg(REG_DEBOUNCE_LIMIT, limit);
		write_reg(REG_RUN_LENGTH_CAP, cap);
		write_reg(REG_WINDOW_TICKS, window);
	endtask

	task automatic send_pattern(input logic [31:0] bits, input int n);
		for (int k = n - 1; k >= 0; k--)
			send_tick(bits[k]);
	endtask

	// Reset register values, a short glitch, a clean assertion and release.
	task automatic test_reset_values();
		send_pattern(32'b1000010111, 10);
		wait_idle();
	endtask

	// Zero limit never asserts; zero window latches on every tick; small cap saturates.
	task automatic test_zero_limit_and_window();
		apply_settings(0, 2, 0);
		send_pattern(32'b000111, 6);
		wait_idle();
	endtask

	// Lower limit and cap beneath the running integrator and run counter.
	task automatic test_lowered_limits();
		apply_settings(5, 6, 1);
		send_pattern(32'b000000, 6);
		wait_idle();
		write_reg(REG_DEBOUNCE_LIMIT, 2);
		write_reg(REG_RUN_LENGTH_CAP, 3);
		send_pattern(32'b00111110, 8);
		wait_idle();
	endtask

	// Mostly clean runs around the limit, some runs past the cap, some glitch noise.
	task automatic test_random_ticks(input int n, input int limit, input int cap, input int window);
		int   sent;
		int   len;
		int   kind;
		logic lvl;
		sent = 0;
		apply_settings(limit, cap, window);
		while (sent < n) begin
			kind = $urandom_range(99);
			lvl  = 1'($urandom_range(1));
			if (kind < 70)
				len = $urandom_range(2 * limit + 4, 1);
			else if (kind < 80)
				len = $urandom_range(cap + 8, (cap > 0) ? cap : 1);
			else
				len = $urandom_range(4, 1);
			for (int k = 0; k < len && sent < n; k++) begin
				send_tick((kind >= 80) ? 1'($urandom_range(1)) : lvl);
				sent++;
			end
		end
		wait_idle();
	endtask

	// Hold the output side for a long stretch while words keep coming.
	task automatic test_output_stall(input int n);
		apply_settings(2, 8, 20);
		fork
			begin
				@(posedge clk);
				hold_output = 1'b1;
				repeat (300) @(posedge clk);
				hold_output = 1'b0;
			end
			for (int k = 0; k < n; k++)
				send_tick(1'($urandom_range(1)));
		join
		wait_idle();
	endtask

	always @(negedge clk)
		out_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);

	task automatic note_mismatch(input string what, input logic [15:0] want_v,
			input logic [15:0] got_v);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tick_results_due.size() == 0) begin
				mismatches++;
				$display("%0t ns: result word with none expected", $time);
			end else begin
				want = tick_results_due.pop_front();
				if (debounced_active !== want.debounced_active)
					note_mismatch("debounced_active", 16'(want.debounced_active),
						16'(debounced_active));
				if (wheel_pulse !== want.wheel_pulse)
					note_mismatch("wheel_pulse", 16'(want.wheel_pulse), 16'(wheel_pulse));
				if (inactive_run_length !== want.inactive_run_length)
					note_mismatch("inactive_run_length", 16'(want.inactive_run_length),
						16'(inactive_run_length));
				if (active_run_length !== want.active_run_length)
					note_mismatch("active_run_length", 16'(want.active_run_length),
						16'(active_run_length));
				if (speed_count !== want.speed_count)
					note_mismatch("speed_count", want.speed_count, speed_count);
				if (window_done !== want.window_done)
					note_mismatch("window_done", 16'(want.window_done), 16'(window_done));
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		pin_level = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_zero_limit_and_window();
		test_lowered_limits();

		send_idle_pct = 14;
		recv_idle_pct = 46;
		test_random_ticks(400, 4, 12, 37);
		test_random_ticks(250, 1, 0, 1);
		test_output_stall(120);

		send_idle_pct = 46;
		recv_idle_pct = 14;
		test_random_ticks(450, 255, 255, 65535);
		test_random_ticks(300, $urandom_range(8, 1), $urandom_range(30, 1),
			$urandom_range(100, 2));

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_ticks(450, $urandom_range(16, 1), $urandom_range(64, 1),
			$urandom_range(300, 1));

		if (mismatches == 0)
			$display("** wheel_sensor_debounce_tachometer: PASSED **");
		else
			$display("** wheel_sensor_debounce_tachometer: FAILED **");
		$finish;
	end

endmodule

### wheel_sensor_debounce_tachometer.f
+incdir+src
src/wsdt_pkg.sv
src/wsdt_regs.sv
src/wsdt_core.sv
src/wheel_sensor_debounce_tachometer.sv
test/tb_top.sv
